FILE: rtl/core/swmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmm_pkg
// shared types and constants of the sliding window min / max / mean core
// ----------------------------------------------------------------------------
package swmm_pkg;

	localparam int SAMPLE_W      = 32;
	localparam int WIN_W         = 9;
	localparam int DEF_MAX_DEPTH = 256;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [WIN_W-1:0]    win_t;
	typedef logic                op_t;

	localparam win_t    WIN_RESET  = win_t'(256);
	localparam op_t     OP_PUSH    = 1'b0;
	localparam op_t     OP_QUERY   = 1'b1;
	localparam sample_t SAMPLE_MAX = '1;

endpackage
`default_nettype wire

FILE: rtl/core/swmm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmm_if
// request and response channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface swmm_req_if;
	logic              valid;
	logic              ready;
	swmm_pkg::op_t     op;
	swmm_pkg::sample_t sample;

	modport source (output valid, output op, output sample, input ready);
	modport sink   (input valid, input op, input sample, output ready);
endinterface

interface swmm_rsp_if;
	logic              valid;
	logic              ready;
	logic              has_records;
	swmm_pkg::sample_t minimum;
	swmm_pkg::sample_t maximum;
	swmm_pkg::sample_t mean;

	modport source (output valid, output has_records, output minimum, output maximum,
		output mean, input ready);
	modport sink   (input valid, input has_records, input minimum, input maximum,
		input mean, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sliding_window_min_max_mean_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_min_max_mean_core
// windowed minimum, maximum and truncated mean over the latest samples
//
//  channel  dir  handshake              payload
//  req      in   valid / ready          op, sample
//  rsp      out  valid / ready          has_records, minimum, maximum, mean
//  cfg      in   cfg_we, no back-press  cfg_wdata (window length)
//
// push: taken while idle; the block stays idle, so the next request can be taken in the next cycle
// query: the single memory read port walks one entry a cycle, then the divider
//   delivers one quotient bit a cycle
// query on an empty window: skips the scan and the divider
// reset: all control clear at once, window length 256, no memory sweep
// a held result does not block pushes; the next query waits for it
// ----------------------------------------------------------------------------
module sliding_window_min_max_mean_core #(
	parameter int MAX_DEPTH = swmm_pkg::DEF_MAX_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	swmm_req_if.sink            req,
	swmm_rsp_if.source          rsp,
	input  wire logic           cfg_we,
	input  wire swmm_pkg::win_t cfg_wdata
);
	import swmm_pkg::*;

	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int CW = $clog2(MAX_DEPTH + 1);
	localparam int SW = SAMPLE_W + CW;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_TAIL   = 3'd2;
	localparam logic [2:0] ST_DSTART = 3'd3;
	localparam logic [2:0] ST_DWAIT  = 3'd4;
	localparam logic [2:0] ST_LOAD   = 3'd5;

	logic [2:0]    state_q;
	logic [AW-1:0] idx_q;
	logic [CW-1:0] cnt_q;
	logic          rd_vld_s1;
	sample_t       min_q;
	sample_t       max_q;
	logic [SW-1:0] sum_q;
	logic          out_vld_q;
	logic          out_has_q;
	sample_t       out_min_q;
	sample_t       out_max_q;
	sample_t       out_mean_q;

	logic          acc;
	logic          push;
	logic          query;
	logic          rd_en;
	logic          last_rd;
	logic          load;
	sample_t       rd_data;
	logic [CW-1:0] count;
	logic [SW-1:0] quotient;
	logic          div_start;
	logic          div_done;

	assign req.ready = (state_q == ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign push      = acc && (req.op == OP_PUSH);
	assign query     = acc && (req.op == OP_QUERY);
	assign rd_en     = (state_q == ST_SCAN);
	assign last_rd   = (CW'(idx_q) == cnt_q - CW'(1));
	assign load      = (state_q == ST_LOAD) && (!out_vld_q || rsp.ready);
	assign div_start = (state_q == ST_DSTART);

	swmm_store #(
		.MAX_DEPTH (MAX_DEPTH),
		.AW        (AW),
		.CW        (CW)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.wr_en     (push),
		.wr_data   (req.sample),
		.rd_en     (rd_en),
		.rd_addr   (idx_q),
		.rd_data   (rd_data),
		.count     (count)
	);

	swmm_div #(
		.NW (SW),
		.DW (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			unique case (state_q)
				ST_IDLE: begin
					if (query) begin
						idx_q   <= '0;
						state_q <= (count == '0) ? ST_LOAD : ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + AW'(1);
					if (last_rd) begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					state_q <= ST_DSTART;
				end
				ST_DSTART: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (div_done) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// shared compare / accumulate unit
	always_ff @(posedge clk) begin
		if (query) begin
			cnt_q <= count;
			min_q <= SAMPLE_MAX;
			max_q <= '0;
			sum_q <= '0;
		end else if (rd_vld_s1) begin
			if (rd_data < min_q) begin
				min_q <= rd_data;
			end
			if (rd_data > max_q) begin
				max_q <= rd_data;
			end
			sum_q <= sum_q + SW'(rd_data);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_has_q  <= (cnt_q != '0);
			out_min_q  <= (cnt_q != '0) ? min_q : '0;
			out_max_q  <= (cnt_q != '0) ? max_q : '0;
			out_mean_q <= (cnt_q != '0) ? quotient[SAMPLE_W-1:0] : '0;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.has_records = out_has_q;
	assign rsp.minimum     = out_min_q;
	assign rsp.maximum     = out_max_q;
	assign rsp.mean        = out_mean_q;

endmodule
`default_nettype wire

FILE: rtl/core/swmm_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmm_store
// ring sample memory with write pointer, fill count and window length register
// ----------------------------------------------------------------------------
module swmm_store #(
	parameter int MAX_DEPTH = swmm_pkg::DEF_MAX_DEPTH,
	parameter int AW        = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1,
	parameter int CW        = $clog2(MAX_DEPTH + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire swmm_pkg::win_t    cfg_wdata,
	input  wire logic              wr_en,
	input  wire swmm_pkg::sample_t wr_data,
	input  wire logic              rd_en,
	input  wire logic [AW-1:0]     rd_addr,
	output swmm_pkg::sample_t      rd_data,
	output logic [CW-1:0]          count
);
	import swmm_pkg::*;

	localparam int XW = (CW > WIN_W) ? CW : WIN_W;

	sample_t       mem_q [MAX_DEPTH];
	win_t          win_q;
	logic [AW-1:0] pos_q;
	logic [CW-1:0] count_q;
	logic [XW-1:0] win_x;
	logic [CW-1:0] len;
	logic [AW-1:0] wr_addr;
	logic [CW-1:0] wr_next;

	// clamp window length to 1 .. MAX_DEPTH
	always_comb begin
		win_x = XW'(win_q);
		if (win_x == '0) begin
			len = CW'(1);
		end else if (win_x > XW'(MAX_DEPTH)) begin
			len = CW'(MAX_DEPTH);
		end else begin
			len = CW'(win_x);
		end
		wr_addr = (CW'(pos_q) >= len) ? '0 : pos_q;
		wr_next = CW'(wr_addr) + CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= WIN_RESET;
			pos_q   <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			win_q   <= cfg_wdata;
			pos_q   <= '0;
			count_q <= '0;
		end else if (wr_en) begin
			pos_q <= (wr_next >= len) ? '0 : AW'(wr_next);
			if (count_q < len) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

	assign count = count_q;

endmodule
`default_nettype wire

FILE: rtl/core/swmm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module swmm_div #(
	parameter int NW = 41,
	parameter int DW = 9
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [NW-1:0]      quotient
);
	localparam int KW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [KW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          ge;

	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		ge    = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= KW'(NW);
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - KW'(1);
			busy_q <= (cnt_q != KW'(1));
			done_q <= (cnt_q == KW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? DW'(trial - {1'b0, dvs_q}) : DW'(trial);
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

FILE: rtl/core/swmm_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmm_chk
// port-level checks of the sliding window core, bound to the top level
// ----------------------------------------------------------------------------
module swmm_chk (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire swmm_pkg::op_t     req_op,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire logic              rsp_has_records,
	input wire swmm_pkg::sample_t rsp_minimum,
	input wire swmm_pkg::sample_t rsp_maximum,
	input wire swmm_pkg::sample_t rsp_mean
);
	import swmm_pkg::*;

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mean)
			&& $stable(rsp_minimum) && $stable(rsp_maximum))
		else $error("response changed while stalled");

	// a query keeps the block busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_op == OP_QUERY |=> !req_ready)
		else $error("request accepted right after a query");

	// a push makes no response
	a_push_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_op == OP_PUSH && !rsp_valid |=> !rsp_valid)
		else $error("response appeared after a push");

	// empty window gives zero fields
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_has_records |->
			rsp_minimum == '0 && rsp_maximum == '0 && rsp_mean == '0)
		else $error("nonzero fields on empty window");

	// mean lies between minimum and maximum
	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_has_records |->
			rsp_minimum <= rsp_mean && rsp_mean <= rsp_maximum)
		else $error("mean outside min / max");

endmodule

bind sliding_window_min_max_mean_core swmm_chk u_swmm_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_op          (req.op),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_has_records (rsp.has_records),
	.rsp_minimum     (rsp.minimum),
	.rsp_maximum     (rsp.maximum),
	.rsp_mean        (rsp.mean)
);
`default_nettype wire

FILE: dv/sliding_window_min_max_mean_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_min_max_mean_core_test
// self-checking bench for the windowed min / max / mean core: a directed
// set covers the empty window, sample extremes, window lengths of zero, one
// and above the store depth and the ring wrap, then random push / query
// traffic runs over a series of window lengths. every response is compared
// with a local model of the ring store; both channels stall at random.
// ----------------------------------------------------------------------------
module sliding_window_min_max_mean_core_test;
	import swmm_pkg::*;

	localparam int DEPTH = DEF_MAX_DEPTH;

	typedef struct {
		logic    has_records;
		sample_t minimum;
		sample_t maximum;
		sample_t mean;
	} window_stats_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	win_t cfg_wdata;

	swmm_req_if req_ch ();
	swmm_rsp_if rsp_ch ();

	sliding_window_min_max_mean_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// ring store model
	sample_t     window_store [DEPTH];
	int unsigned write_slot;
	int unsigned held_count;
	win_t        window_len;

	window_stats_t pending_stats [$];

	bit steady;
	int fail_count;
	int request_count;
	int query_count;
	int checked_count;
	int setting_count;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic int unsigned active_length();
		if (window_len == 0)
			return 1;
		if (window_len > DEPTH)
			return DEPTH;
		return window_len;
	endfunction

	function automatic void apply_request(input op_t op, input sample_t value);
		int unsigned   len;
		logic [39:0]   total;
		window_stats_t stats;
		len = active_length();
		if (op == OP_PUSH) begin
			if (write_slot >= len)
				write_slot = 0;
			window_store[write_slot] = value;
			write_slot++;
			if (write_slot >= len)
				write_slot = 0;
			if (held_count < len)
				held_count++;
			return;
		end
		stats = '{1'b0, '0, '0, '0};
		if (held_count != 0) begin
			stats.has_records = 1'b1;
			stats.minimum     = SAMPLE_MAX;
			total             = '0;
			for (int i = 0; i < held_count; i++) begin
				if (window_store[i] < stats.minimum)
					stats.minimum = window_store[i];
				if (window_store[i] > stats.maximum)
					stats.maximum = window_store[i];
				total += 40'(window_store[i]);
			end
			stats.mean = sample_t'(total / 40'(held_count));
		end
		pending_stats.push_back(stats);
		query_count++;
	endfunction

	task automatic send_request(input op_t op, input sample_t value);
		while (!steady && $urandom_range(99) < 23) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.op     <= op;
		req_ch.sample <= value;
		do @(posedge clk); while (!req_ch.ready);
		apply_request(op, value);
		request_count++;
	endtask

	task automatic write_window(input win_t len);
		req_ch.valid <= 1'b0;
		while (pending_stats.size() != 0)
			@(posedge clk);
		// a trailing push may still be in flight
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		window_len = len;
		write_slot = 0;
		held_count = 0;
		setting_count++;
		cfg_we <= 1'b0;
	endtask

	function automatic sample_t pick_sample();
		case ($urandom_range(9))
			0:       return '0;
			1:       return SAMPLE_MAX;
			2, 3:    return sample_t'($urandom_range(15));
			4:       return {16'($urandom), 16'h0000};
			5:       return SAMPLE_MAX - sample_t'($urandom_range(15));
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic push_sample(input sample_t value);
		send_request(OP_PUSH, value);
	endtask

	task automatic query_window();
		send_request(OP_QUERY, sample_t'($urandom));
	endtask

	// response check
	initial begin
		window_stats_t want;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				checked_count++;
				if (pending_stats.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected response: has=%0b min=%h max=%h mean=%h",
							rsp_ch.has_records, rsp_ch.minimum, rsp_ch.maximum,
							rsp_ch.mean);
				end else begin
					want = pending_stats.pop_front();
					if (rsp_ch.has_records !== want.has_records ||
						rsp_ch.minimum !== want.minimum ||
						rsp_ch.maximum !== want.maximum ||
						rsp_ch.mean !== want.mean) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected has=%0b min=%h max=%h mean=%h, got has=%0b min=%h max=%h mean=%h",
								want.has_records, want.minimum, want.maximum, want.mean,
								rsp_ch.has_records, rsp_ch.minimum, rsp_ch.maximum,
								rsp_ch.mean);
					end
				end
			end
			rsp_ch.ready <= steady || ($urandom_range(99) >= 23);
		end
	end

	task automatic test_reset_state();
		query_window();
		push_sample('0);
		query_window();
	endtask

	task automatic test_extremes();
		push_sample(SAMPLE_MAX);
		push_sample(sample_t'(1));
		query_window();
	endtask

	task automatic test_single_slot_window();
		write_window(win_t'(1));
		query_window();
		push_sample(sample_t'(5));
		push_sample(32'hFFFF_0000);
		query_window();
	endtask

	task automatic test_window_zero();
		write_window(win_t'(0));
		push_sample(sample_t'(9));
		push_sample(sample_t'(3));
		query_window();
	endtask

	task automatic test_window_saturate();
		write_window(win_t'(511));
		push_sample(SAMPLE_MAX);
		push_sample(SAMPLE_MAX);
		query_window();
	endtask

	task automatic test_ring_wrap();
		write_window(win_t'(3));
		push_sample(sample_t'(10));
		push_sample(sample_t'(20));
		push_sample(sample_t'(30));
		push_sample(sample_t'(40));
		query_window();
		push_sample('0);
		query_window();
	endtask

	task automatic run_phase(input win_t len, input int count, input int query_pct);
		write_window(len);
		repeat (count) begin
			if ($urandom_range(99) < query_pct)
				query_window();
			else
				push_sample(pick_sample());
		end
	endtask

	task automatic test_random_traffic();
		run_phase(win_t'($urandom_range(2, 8)), 150, 30);
		run_phase(win_t'(1), 100, 30);
		steady = 1'b1;
		run_phase(win_t'($urandom_range(9, 40)), 200, 25);
		steady = 1'b0;
		run_phase(win_t'(DEPTH), 420, 15);
		run_phase(win_t'(0), 80, 30);
		run_phase(win_t'($urandom_range(257, 511)), 300, 10);
		run_phase(win_t'($urandom_range(2, 64)), 200, 30);
		run_phase(win_t'($urandom_range(1, 255)), 200, 25);
		run_phase(win_t'($urandom_range(2, 16)), 200, 40);
	endtask

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= WIN_RESET;
		req_ch.valid  <= 1'b0;
		req_ch.op     <= OP_PUSH;
		req_ch.sample <= '0;
		window_len    = WIN_RESET;
		write_slot    = 0;
		held_count    = 0;
		foreach (window_store[i])
			window_store[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_extremes();
		test_single_slot_window();
		test_window_zero();
		test_window_saturate();
		test_ring_wrap();
		test_random_traffic();

		req_ch.valid <= 1'b0;
		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("sent %0d requests (%0d queries) over %0d window settings",
			request_count, query_count, setting_count);
		$display("checked %0d responses, %0d failures", checked_count, fail_count);
		if (fail_count == 0 && pending_stats.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
